// ----- sv/msa_pkg.sv -----
// Shared types and constants for the MIPS R/I-type execute block.
// Holds opcode and function codes, the decoded item, and the queue sizing.
// No dependencies.
`timescale 1ns / 1ps

package msa_pkg;

    localparam int REG_IDX_W = 5;
    localparam int IMM_W     = 16;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;

    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_ADDI  = 6'h08;
    localparam logic [5:0] OPC_ANDI  = 6'h0C;
    localparam logic [5:0] OPC_ORI   = 6'h0D;

    localparam logic [5:0] FN_SLL = 6'h00;
    localparam logic [5:0] FN_SRA = 6'h03;
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_AND = 6'h24;
    localparam logic [5:0] FN_OR  = 6'h25;
    localparam logic [5:0] FN_NOR = 6'h27;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_FUNCT  = 2'd1,
        ST_BAD_OPCODE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_SLL,
        OP_SRA,
        OP_ADD,
        OP_SUB,
        OP_AND,
        OP_OR,
        OP_NOR
    } t_alu_op;

    typedef struct packed {
        t_status                status;
        t_alu_op                alu_op;
        logic [REG_IDX_W-1:0]   rs;
        logic [REG_IDX_W-1:0]   rt;
        logic [REG_IDX_W-1:0]   dest;
        logic [REG_IDX_W-1:0]   shamt;
        logic [IMM_W-1:0]       imm;
        logic                   use_imm;
        logic                   imm_sext;
    } t_dec;

endpackage

// ----- sv/msa_if.sv -----
// Handshake channels of the execute block: instruction in, result out.
// Depends on nothing; the result channel is sized by DATA_WIDTH.
`timescale 1ns / 1ps

interface msa_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface msa_result_if #(
    parameter int DATA_WIDTH = 16
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [4:0]            dest_index;
    logic [DATA_WIDTH-1:0] dest_value;

    modport source (output valid, output status, output dest_index, output dest_value,
                    input ready);
    modport sink   (input valid, input status, input dest_index, input dest_value,
                    output ready);
endinterface

// ----- sv/msa_front.sv -----
// Front end: takes instruction words and classifies them into decoded items.
// Depends on msa_pkg and msa_instr_if.
`timescale 1ns / 1ps

module msa_front (
    msa_instr_if.sink       i_instr,
    input  logic            i_full,
    output logic            o_push,
    output msa_pkg::t_dec   o_item
);
    import msa_pkg::*;

    logic [31:0] w;
    logic [5:0]  opcode;
    logic [5:0]  funct;
    t_dec        dec;

    assign w      = i_instr.instruction_word;
    assign opcode = w[31:26];
    assign funct  = w[5:0];

    always_comb begin
        dec          = '0;
        dec.status   = ST_OK;
        dec.alu_op   = OP_ADD;
        dec.rs       = w[25:21];
        dec.rt       = w[20:16];
        dec.dest     = w[20:16];
        dec.shamt    = w[10:6];
        dec.imm      = w[15:0];
        dec.use_imm  = 1'b0;
        dec.imm_sext = 1'b0;
        case (opcode)
            OPC_RTYPE: begin
                dec.dest = w[15:11];
                case (funct)
                    FN_SLL:  dec.alu_op = OP_SLL;
                    FN_SRA:  dec.alu_op = OP_SRA;
                    FN_ADD:  dec.alu_op = OP_ADD;
                    FN_SUB:  dec.alu_op = OP_SUB;
                    FN_AND:  dec.alu_op = OP_AND;
                    FN_OR:   dec.alu_op = OP_OR;
                    FN_NOR:  dec.alu_op = OP_NOR;
                    default: dec.status = ST_BAD_FUNCT;
                endcase
            end
            OPC_ADDI: begin
                dec.alu_op   = OP_ADD;
                dec.use_imm  = 1'b1;
                dec.imm_sext = 1'b1;
            end
            OPC_ANDI: begin
                dec.alu_op  = OP_AND;
                dec.use_imm = 1'b1;
            end
            OPC_ORI: begin
                dec.alu_op  = OP_OR;
                dec.use_imm = 1'b1;
            end
            default: dec.status = ST_BAD_OPCODE;
        endcase
        // rejected items report register zero
        if (dec.status != ST_OK) begin
            dec.dest = '0;
        end
    end

    assign i_instr.ready = !i_full;
    assign o_push        = i_instr.valid && !i_full;
    assign o_item        = dec;

endmodule

// ----- sv/msa_queue.sv -----
// Short FIFO of decoded items between the front end and the execute back end.
// Depends on msa_pkg.
`timescale 1ns / 1ps

module msa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  msa_pkg::t_dec   i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_vld,
    output msa_pkg::t_dec   o_item
);
    import msa_pkg::*;

    localparam logic [QPTR_W:0] CNT_FULL = (QPTR_W + 1)'(QDEPTH);

    t_dec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QPTR_W:0]   r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_vld   = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ----- sv/msa_back.sv -----
// Back end: register file read, ALU execute with write bypass, result register.
// Depends on msa_pkg and msa_result_if.
`timescale 1ns / 1ps

module msa_back #(
    parameter int NUM_REGS   = 32,
    parameter int DATA_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_vld,
    input  msa_pkg::t_dec   i_item,
    output logic            o_pop,
    msa_result_if.source    o_result
);
    import msa_pkg::*;

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int LIM_W = REG_IDX_W + 1;
    localparam logic [LIM_W-1:0] REG_LIM = LIM_W'(NUM_REGS);

    // register file and its per-entry valid bits (entry reads zero until written)
    logic [DATA_WIDTH-1:0] r_mem [NUM_REGS];
    logic [NUM_REGS-1:0]   r_rf_vld;

    // execute stage
    logic                  r_x_vld;
    t_dec                  r_x;
    logic [DATA_WIDTH-1:0] r_rd_a;
    logic [DATA_WIDTH-1:0] r_rd_b;
    logic                  r_a_ok;
    logic                  r_b_ok;

    // write that happened at the edge the current item entered execute
    logic                  r_byp_vld;
    logic [REG_IDX_W-1:0]  r_byp_idx;
    logic [DATA_WIDTH-1:0] r_byp_data;

    // result register
    logic                  r_out_vld;
    t_status               r_out_status;
    logic [REG_IDX_W-1:0]  r_out_dest;
    logic [DATA_WIDTH-1:0] r_out_value;

    logic                  x_adv;
    logic                  enter;
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] op_a;
    logic [DATA_WIDTH-1:0] reg_b;
    logic [DATA_WIDTH-1:0] op_b;
    logic [DATA_WIDTH-1:0] imm_ext;
    logic [DATA_WIDTH-1:0] res;
    logic [DATA_WIDTH-1:0] out_val;

    function automatic logic in_range(input logic [REG_IDX_W-1:0] idx);
        return {1'b0, idx} < REG_LIM;
    endfunction

    assign x_adv = r_x_vld && (!r_out_vld || o_result.ready);
    assign enter = i_q_vld && (!r_x_vld || x_adv);
    assign o_pop = enter;

    // operands: forward the write made as this item entered, else the read data
    always_comb begin
        if (r_byp_vld && (r_byp_idx == r_x.rs)) begin
            op_a = r_byp_data;
        end else begin
            op_a = r_a_ok ? r_rd_a : '0;
        end
        if (r_byp_vld && (r_byp_idx == r_x.rt)) begin
            reg_b = r_byp_data;
        end else begin
            reg_b = r_b_ok ? r_rd_b : '0;
        end
        for (int i = 0; i < DATA_WIDTH; i++) begin
            if (i < IMM_W) begin
                imm_ext[i] = r_x.imm[i];
            end else begin
                imm_ext[i] = r_x.imm_sext && r_x.imm[IMM_W-1];
            end
        end
        op_b = r_x.use_imm ? imm_ext : reg_b;
    end

    always_comb begin
        case (r_x.alu_op)
            OP_SLL:  res = reg_b << r_x.shamt;
            OP_SRA:  res = DATA_WIDTH'($signed(reg_b) >>> r_x.shamt);
            OP_ADD:  res = op_a + op_b;
            OP_SUB:  res = op_a - op_b;
            OP_AND:  res = op_a & op_b;
            OP_OR:   res = op_a | op_b;
            OP_NOR:  res = ~(op_a | op_b);
            default: res = '0;
        endcase
        out_val = (r_x.status == ST_OK) ? res : '0;
    end

    // drop writes to registers beyond the file
    assign wr_en = x_adv && (r_x.status == ST_OK) && in_range(r_x.dest);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_x.dest[IDX_W-1:0]] <= res;
        end
        if (enter) begin
            r_rd_a <= r_mem[i_item.rs[IDX_W-1:0]];
            r_rd_b <= r_mem[i_item.rt[IDX_W-1:0]];
            r_a_ok <= in_range(i_item.rs) && r_rf_vld[i_item.rs[IDX_W-1:0]];
            r_b_ok <= in_range(i_item.rt) && r_rf_vld[i_item.rt[IDX_W-1:0]];
            r_x    <= i_item;
            r_byp_idx  <= r_x.dest;
            r_byp_data <= res;
        end
        if (x_adv) begin
            r_out_status <= r_x.status;
            r_out_dest   <= r_x.dest;
            r_out_value  <= out_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld  <= '0;
            r_x_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_byp_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_rf_vld[r_x.dest[IDX_W-1:0]] <= 1'b1;
            end
            if (enter) begin
                r_byp_vld <= wr_en;
            end
            if (enter) begin
                r_x_vld <= 1'b1;
            end else if (x_adv) begin
                r_x_vld <= 1'b0;
            end
            if (x_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_result.valid      = r_out_vld;
    assign o_result.status     = r_out_status;
    assign o_result.dest_index = r_out_dest;
    assign o_result.dest_value = r_out_value;

endmodule

// ----- sv/mips_subset_alu_regfile_unit.sv -----
// MIPS R/I-type execute unit: instruction word in, write-back result out.
// Usage:
//   i_instr  carries one 32-bit instruction word per transfer (valid/ready).
//   o_result carries status, dest_index and dest_value per transfer; every
//   accepted instruction gives exactly one result, in order.
//   Supported: SLL, SRA, ADD, SUB, AND, OR, NOR (opcode 0), ADDI, ANDI, ORI.
//   Unknown function codes report status 1, unknown opcodes status 2; both
//   write nothing and report index and value zero.
// Timing:
//   An instruction is decoded into a 4-entry queue, reads the register file as
//   it enters the execute stage, then executes into the output register. One
//   instruction per cycle is sustained while o_result.ready stays high; a result
//   that depends on the previous instruction's write is forwarded from execute.
// Reset (i_rst_n low, synchronous): queue and pipeline empty, all registers
//   read as zero; no clearing pass is needed.
// Stall: while o_result.ready is low, the output register and the execute
//   stage hold, the queue fills, and i_instr.ready drops once the queue is full.
// Depends on msa_pkg, msa_if, msa_front, msa_queue and msa_back.
`timescale 1ns / 1ps

module mips_subset_alu_regfile_unit #(
    parameter int NUM_REGS   = 32,
    parameter int DATA_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    msa_instr_if.sink     i_instr,
    msa_result_if.source  o_result
);
    import msa_pkg::*;

    logic push;
    logic pop;
    logic q_full;
    logic q_vld;
    t_dec front_item;
    t_dec head_item;

    msa_front u_front (
        .i_instr (i_instr),
        .i_full  (q_full),
        .o_push  (push),
        .o_item  (front_item)
    );

    msa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_item  (head_item)
    );

    msa_back #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_vld  (q_vld),
        .i_item   (head_item),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for mips_subset_alu_regfile_unit: drives instruction words
// and checks every write-back against a register-file predictor in a scoreboard.
// Depends on msa_pkg, msa_if and the execute unit RTL.
`timescale 1ns / 1ps

module tb;
    import msa_pkg::*;

    localparam int          NUM_INSTRS   = 1550;
    localparam int          HOLDOFF_LEN  = 80;
    localparam int          IDLE_LIMIT   = 1000;
    localparam int          DRAIN_CYCLES = 10;
    // Codes outside the supported subset
    localparam logic [5:0]  FN_UNLISTED  = 6'h21;
    localparam logic [5:0]  FN_ALL_ONES  = 6'h3F;
    localparam logic [5:0]  OPC_UNLISTED = 6'h23;
    localparam logic [5:0]  OPC_JUMP     = 6'h02;

    typedef struct packed {
        t_status     status;
        logic [4:0]  dest_index;
        logic [15:0] dest_value;
    } t_writeback;

    class writeback_scoreboard;
        logic [15:0] regs [32];
        t_writeback  pending[$];
        int          mismatches;
        int          checked;

        function new();
            foreach (regs[i]) regs[i] = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        // Execute one instruction on the shadow register file.
        function t_writeback execute(logic [31:0] word);
            logic [5:0]         opc;
            logic [5:0]         fn;
            logic [4:0]         rs;
            logic [4:0]         rt;
            logic [4:0]         sh;
            logic [15:0]        a;
            logic [15:0]        b;
            logic [15:0]        imm;
            logic signed [15:0] sb;
            t_writeback         res;
            opc = word[31:26];
            rs  = word[25:21];
            rt  = word[20:16];
            sh  = word[10:6];
            fn  = word[5:0];
            imm = word[15:0];
            a   = regs[rs];
            b   = regs[rt];
            sb  = b;
            res.status     = ST_OK;
            res.dest_value = '0;
            if (opc == OPC_RTYPE) begin
                res.dest_index = word[15:11];
                case (fn)
                    FN_SLL: res.dest_value = b << sh;
                    FN_SRA: res.dest_value = sb >>> sh;
                    FN_ADD: res.dest_value = a + b;
                    FN_SUB: res.dest_value = a - b;
                    FN_AND: res.dest_value = a & b;
                    FN_OR:  res.dest_value = a | b;
                    FN_NOR: res.dest_value = ~(a | b);
                    default: res.status = ST_BAD_FUNCT;
                endcase
            end else begin
                res.dest_index = rt;
                // sign extension of the ADDI immediate is a no-op at 16 bits
                case (opc)
                    OPC_ADDI: res.dest_value = a + imm;
                    OPC_ANDI: res.dest_value = a & imm;
                    OPC_ORI:  res.dest_value = a | imm;
                    default:  res.status = ST_BAD_OPCODE;
                endcase
            end
            if (res.status == ST_OK) begin
                regs[res.dest_index] = res.dest_value;
            end else begin
                res.dest_index = '0;
                res.dest_value = '0;
            end
            return res;
        endfunction

        function void note_instr(logic [31:0] word);
            pending.push_back(execute(word));
        endfunction

        function void check_writeback(logic [1:0] status, logic [4:0] dest_index,
                                      logic [15:0] dest_value);
            t_writeback exp;
            if (pending.size() == 0) begin
                $error("unexpected write-back: status %0d index %0d value 0x%04h",
                       status, dest_index, dest_value);
                mismatches++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, status);
                mismatches++;
            end
            if (dest_index !== exp.dest_index) begin
                $error("dest_index: expected %0d, got %0d", exp.dest_index, dest_index);
                mismatches++;
            end
            if (dest_value !== exp.dest_value) begin
                $error("dest_value: expected 0x%04h, got 0x%04h", exp.dest_value, dest_value);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    msa_instr_if                        instr_ch();
    msa_result_if #(.DATA_WIDTH(16))    result_ch();

    mips_subset_alu_regfile_unit #(
        .NUM_REGS   (32),
        .DATA_WIDTH (16)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_ch),
        .o_result (result_ch)
    );

    always #2 i_clk = ~i_clk;

    writeback_scoreboard sb = new();

    int         instrs_sent      = 0;
    int         holdoff_requests = 0;
    int         holdoffs_done    = 0;
    bit         burst_mode       = 1'b0;
    logic [4:0] recent_dest      = '0;

    // Mostly no gap, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                           logic [4:0] sh, logic [5:0] fn);
        return {OPC_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_word(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    // Well-formed instructions with random operands, biased toward reading the
    // last destination so the forwarding path gets exercised; the rest is noise.
    function automatic logic [31:0] random_instr();
        int          sel;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [15:0] imm;
        logic [31:0] word;
        sel = $urandom_range(0, 99);
        rs  = 5'($urandom);
        rt  = 5'($urandom);
        rd  = 5'($urandom);
        sh  = 5'($urandom);
        imm = 16'($urandom);
        if ($urandom_range(0, 2) == 0) rs = recent_dest;
        if ($urandom_range(0, 2) == 0) rt = recent_dest;
        case ($urandom_range(0, 7))
            0: imm = 16'h0000;
            1: imm = 16'hFFFF;
            2: imm = 16'h7FFF;
            3: imm = 16'h8000;
            default: ;
        endcase
        if (sel < 8) begin
            word = $urandom;
        end else if (sel < 14) begin
            word = r_word(rs, rt, rd, sh, 6'($urandom));
        end else begin
            case ($urandom_range(0, 9))
                0: word = r_word(rs, rt, rd, sh, FN_SLL);
                1: word = r_word(rs, rt, rd, sh, FN_SRA);
                2: word = r_word(rs, rt, rd, sh, FN_ADD);
                3: word = r_word(rs, rt, rd, sh, FN_SUB);
                4: word = r_word(rs, rt, rd, sh, FN_AND);
                5: word = r_word(rs, rt, rd, sh, FN_OR);
                6: word = r_word(rs, rt, rd, sh, FN_NOR);
                7: word = i_word(OPC_ADDI, rs, rt, imm);
                8: word = i_word(OPC_ANDI, rs, rt, imm);
                default: word = i_word(OPC_ORI, rs, rt, imm);
            endcase
        end
        recent_dest = (word[31:26] == OPC_RTYPE) ? word[15:11] : word[20:16];
        return word;
    endfunction

    task automatic send_instr(input logic [31:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        instr_ch.valid            <= 1'b1;
        instr_ch.instruction_word <= word;
        do @(posedge i_clk); while (!instr_ch.ready);
        sb.note_instr(word);
        instrs_sent++;
    endtask

    // Result side: random stalls plus requested long hold-offs.
    initial begin
        int   stall_left;
        int   g;
        logic next_ready;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready)
                sb.check_writeback(result_ch.status, result_ch.dest_index,
                                   result_ch.dest_value);
            if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (holdoffs_done < holdoff_requests) begin
                holdoffs_done++;
                stall_left = HOLDOFF_LEN - 1;
                next_ready = 1'b0;
            end else begin
                g = pick_gap();
                stall_left = (g > 0) ? g - 1 : 0;
                next_ready = (g == 0);
            end
            result_ch.ready <= next_ready;
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: timeout after %0d idle cycles", IDLE_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        int n;
        i_rst_n                   <= 1'b0;
        instr_ch.valid            <= 1'b0;
        instr_ch.instruction_word <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: immediates at their extremes, wrap, writable register zero
        send_instr(i_word(OPC_ORI,  5'd0, 5'd1, 16'hFFFF));
        send_instr(i_word(OPC_ADDI, 5'd0, 5'd2, 16'h7FFF));
        send_instr(i_word(OPC_ADDI, 5'd0, 5'd3, 16'h8000));
        send_instr(i_word(OPC_ADDI, 5'd1, 5'd0, 16'h0001));
        send_instr(i_word(OPC_ORI,  5'd0, 5'd0, 16'hA5C3));
        send_instr(i_word(OPC_ANDI, 5'd1, 5'd4, 16'h00F0));
        // R-type ALU ops; shamt must be ignored outside the shifts
        send_instr(r_word(5'd1, 5'd2, 5'd5, 5'd0, FN_ADD));
        send_instr(r_word(5'd3, 5'd1, 5'd6, 5'd31, FN_SUB));
        send_instr(r_word(5'd0, 5'd1, 5'd7, 5'd0, FN_AND));
        send_instr(r_word(5'd2, 5'd3, 5'd8, 5'd0, FN_OR));
        send_instr(r_word(5'd0, 5'd0, 5'd9, 5'd0, FN_NOR));
        // Shifts: rs ignored, amounts zero through full width
        send_instr(r_word(5'd31, 5'd1, 5'd10, 5'd0, FN_SLL));
        send_instr(r_word(5'd0, 5'd1, 5'd11, 5'd15, FN_SLL));
        send_instr(r_word(5'd0, 5'd1, 5'd12, 5'd31, FN_SLL));
        send_instr(r_word(5'd7, 5'd3, 5'd13, 5'd31, FN_SRA));
        send_instr(r_word(5'd0, 5'd2, 5'd14, 5'd4, FN_SRA));
        send_instr(r_word(5'd0, 5'd3, 5'd15, 5'd0, FN_SRA));
        // Invalid function codes and opcodes, including the all-ones word
        send_instr(r_word(5'd1, 5'd2, 5'd16, 5'd0, FN_ALL_ONES));
        send_instr(r_word(5'd1, 5'd2, 5'd17, 5'd0, FN_UNLISTED));
        send_instr(32'hFFFF_FFFF);
        send_instr(i_word(OPC_UNLISTED, 5'd1, 5'd18, 16'h1234));
        send_instr(i_word(OPC_JUMP, 5'd2, 5'd19, 16'hFFFF));
        // Dependency chain, each instruction reading the last destination, for the forwarding path
        send_instr(i_word(OPC_ADDI, 5'd31, 5'd31, 16'hFFFF));
        send_instr(r_word(5'd31, 5'd31, 5'd30, 5'd0, FN_ADD));
        send_instr(r_word(5'd0, 5'd30, 5'd29, 5'd1, FN_SRA));

        for (n = 0; n < NUM_INSTRS - 25; n++) begin
            burst_mode = (n % 300) >= 240;
            if (n == 40 || n == 1000)
                holdoff_requests++;
            send_instr(random_instr());
        end
        instr_ch.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d instructions sent, %0d write-backs checked, %0d long hold-offs",
                 instrs_sent, sb.checked, holdoffs_done);
        $display("tb: all R/I-type ops, invalid codes, forwarding chains, random stalls");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
